>>> src/pcn_pkg.sv
// ----------------------------------------------------------------------------
// pcn_pkg: shared types, constants and arithmetic helpers
// Holds the chroma types, the decision constants, the register index codes
// and the small functions that derive the average, chroma, norm and dot.
// ----------------------------------------------------------------------------
package pcn_pkg;

  // Decision constants.
  localparam int unsigned MinPaperNorm2 = 25;
  localparam int unsigned MaxNormRatio  = 9;
  localparam int unsigned CosScale      = 100;
  localparam int unsigned CosLimit      = 81;

  // Division by three of a sum of three channels: multiply by the reciprocal.
  // The error of 683/2048 stays below one third over the whole sum range.
  localparam int unsigned AvgRecip = 683;
  localparam int unsigned AvgShift = 11;

  typedef logic [7:0]         chan_t;
  typedef logic signed [8:0]  chroma_t;
  typedef logic [15:0]        norm_t;
  typedef logic signed [17:0] dot_t;
  typedef logic [31:0]        prod_t;
  typedef logic [38:0]        wide_t;

  typedef struct packed {
    chroma_t r;
    chroma_t g;
    chroma_t b;
  } chroma_vec_t;

  typedef enum logic [1:0] {
    CfgPaperRed   = 2'd0,
    CfgPaperGreen = 2'd1,
    CfgPaperBlue  = 2'd2
  } cfg_idx_e;

  // Word leaving the first stage.
  typedef struct packed {
    logic        valid;
    chan_t       red;
    chan_t       green;
    chan_t       blue;
    chan_t       avg;
    chroma_vec_t chroma;
  } front_t;

  // Word leaving the second stage.
  typedef struct packed {
    logic  valid;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t avg;
    norm_t norm2;
    dot_t  dot;
  } metric_t;

  function automatic chan_t avg3(chan_t r, chan_t g, chan_t b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'(AvgRecip);
    return prod[AvgShift +: 8];
  endfunction

  function automatic chroma_vec_t chroma_of(chan_t r, chan_t g, chan_t b, chan_t a);
    chroma_vec_t v;
    v.r = $signed({1'b0, r}) - $signed({1'b0, a});
    v.g = $signed({1'b0, g}) - $signed({1'b0, a});
    v.b = $signed({1'b0, b}) - $signed({1'b0, a});
    return v;
  endfunction

  function automatic norm_t norm2(chroma_vec_t v);
    logic signed [17:0] rr;
    logic signed [17:0] gg;
    logic signed [17:0] bb;
    rr = 18'(v.r) * 18'(v.r);
    gg = 18'(v.g) * 18'(v.g);
    bb = 18'(v.b) * 18'(v.b);
    return rr[15:0] + gg[15:0] + bb[15:0];
  endfunction

  function automatic dot_t dot3(chroma_vec_t a, chroma_vec_t b);
    dot_t rr;
    dot_t gg;
    dot_t bb;
    rr = 18'(a.r) * 18'(b.r);
    gg = 18'(a.g) * 18'(b.g);
    bb = 18'(a.b) * 18'(b.b);
    return rr + gg + bb;
  endfunction

endpackage

>>> src/pcn_paper_regs.sv
// ----------------------------------------------------------------------------
// pcn_paper_regs: paper colour registers and derived paper chroma
// Holds the three paper channels and registers the paper chroma vector from
// them and its squared norm from the registered chroma.
// ----------------------------------------------------------------------------
module pcn_paper_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  pcn_pkg::chan_t      cfg_data_i,
  output pcn_pkg::chroma_vec_t paper_chroma_o,
  output pcn_pkg::norm_t      paper_norm2_o
);
  import pcn_pkg::*;

  chan_t       red_q, green_q, blue_q;
  chroma_vec_t pc_q;
  norm_t       pn2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= 8'hFF;
      green_q <= 8'hFF;
      blue_q  <= 8'hFF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPaperRed:   red_q   <= cfg_data_i;
        CfgPaperGreen: green_q <= cfg_data_i;
        CfgPaperBlue:  blue_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A white paper has zero chroma, so the derived values reset to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      pn2_q <= '0;
    end else begin
      pc_q  <= chroma_of(red_q, green_q, blue_q, avg3(red_q, green_q, blue_q));
      pn2_q <= norm2(pc_q);
    end
  end

  assign paper_chroma_o = pc_q;
  assign paper_norm2_o  = pn2_q;

  a_norm_follows_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pn2_q == norm2($past(pc_q)))
    else $error("paper norm does not follow paper chroma");

endmodule

>>> src/pcn_front.sv
// ----------------------------------------------------------------------------
// pcn_front: first pipeline stage
// Registers the pixel together with its truncated average and chroma vector.
// ----------------------------------------------------------------------------
module pcn_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  pcn_pkg::chan_t  red_i,
  input  pcn_pkg::chan_t  green_i,
  input  pcn_pkg::chan_t  blue_i,
  output pcn_pkg::front_t front_o
);
  import pcn_pkg::*;

  front_t front_q;
  chan_t  avg_d;

  assign avg_d = avg3(red_i, green_i, blue_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
    end else begin
      front_q.valid  <= accept_i;
      front_q.red    <= red_i;
      front_q.green  <= green_i;
      front_q.blue   <= blue_i;
      front_q.avg    <= avg_d;
      front_q.chroma <= chroma_of(red_i, green_i, blue_i, avg_d);
    end
  end

  assign front_o = front_q;

endmodule

>>> src/pcn_metric.sv
// ----------------------------------------------------------------------------
// pcn_metric: second pipeline stage
// Registers the squared chroma norm and the dot product with the paper chroma.
// ----------------------------------------------------------------------------
module pcn_metric (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcn_pkg::front_t      front_i,
  input  pcn_pkg::chroma_vec_t paper_chroma_i,
  output pcn_pkg::metric_t     metric_o
);
  import pcn_pkg::*;

  metric_t metric_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= '0;
    end else begin
      metric_q.valid <= front_i.valid;
      metric_q.red   <= front_i.red;
      metric_q.green <= front_i.green;
      metric_q.blue  <= front_i.blue;
      metric_q.avg   <= front_i.avg;
      metric_q.norm2 <= norm2(front_i.chroma);
      metric_q.dot   <= dot3(front_i.chroma, paper_chroma_i);
    end
  end

  assign metric_o = metric_q;

endmodule

>>> src/pcn_decide.sv
// ----------------------------------------------------------------------------
// pcn_decide: third and fourth pipeline stages
// Forms the two cosine products and the range checks, then makes the gray
// decision and drives the registered result.
// ----------------------------------------------------------------------------
module pcn_decide (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcn_pkg::metric_t metric_i,
  input  pcn_pkg::norm_t   paper_norm2_i,
  output logic             done_o,
  output pcn_pkg::chan_t   out_red_o,
  output pcn_pkg::chan_t   out_green_o,
  output pcn_pkg::chan_t   out_blue_o,
  output logic             was_neutralized_o
);
  import pcn_pkg::*;

  logic               valid3_q;
  chan_t              red3_q, green3_q, blue3_q, avg3_q;
  prod_t              dot_sq_q;
  prod_t              norm_prod_q;
  logic               eligible_q;
  logic signed [35:0] dot_sq_d;
  logic               eligible_d;
  wide_t              lhs;
  wide_t              rhs;
  logic               gray;

  logic               done_q;
  chan_t              out_red_q, out_green_q, out_blue_q;
  logic               neutral_q;

  // Stage three: products and the cheap range tests.
  assign dot_sq_d   = 36'(metric_i.dot) * 36'(metric_i.dot);
  assign eligible_d = (32'(paper_norm2_i) >= 32'(MinPaperNorm2))
                   && (metric_i.norm2 != '0)
                   && (20'(metric_i.norm2) <= 20'(paper_norm2_i) * 20'(MaxNormRatio))
                   && !metric_i.dot[17] && (metric_i.dot != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else begin
      valid3_q <= metric_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red3_q      <= metric_i.red;
    green3_q    <= metric_i.green;
    blue3_q     <= metric_i.blue;
    avg3_q      <= metric_i.avg;
    dot_sq_q    <= dot_sq_d[31:0];
    norm_prod_q <= 32'(metric_i.norm2) * 32'(paper_norm2_i);
    eligible_q  <= eligible_d;
  end

  // Stage four: cosine test, at least 0.9, with constant scalings.
  assign lhs  = 39'(dot_sq_q) * 39'(CosScale);
  assign rhs  = 39'(norm_prod_q) * 39'(CosLimit);
  assign gray = eligible_q && (lhs >= rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_red_q   <= gray ? avg3_q : red3_q;
    out_green_q <= gray ? avg3_q : green3_q;
    out_blue_q  <= gray ? avg3_q : blue3_q;
    neutral_q   <= gray;
  end

  assign done_o            = done_q;
  assign out_red_o         = out_red_q;
  assign out_green_o       = out_green_q;
  assign out_blue_o        = out_blue_q;
  assign was_neutralized_o = neutral_q;

  a_gray_is_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && neutral_q) |-> (out_red_q == out_green_q && out_green_q == out_blue_q))
    else $error("neutralized pixel has unequal channels");

  a_weak_paper_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(paper_norm2_i) < 32'(MinPaperNorm2) && metric_i.valid) |=> !eligible_q)
    else $error("pixel eligible under a weak paper tint");

endmodule

>>> src/paper_cast_neutralizer.sv
// ----------------------------------------------------------------------------
// paper_cast_neutralizer: removes the paper colour cast from RGB pixels
// A pixel whose chroma points the same way as the paper chroma, and is not
// much stronger, is replaced by gray at its truncated average.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the command channel: a word is taken at each rising edge
//   with start high and busy low. busy is always low, so one pixel can be
//   taken in every cycle and the sustained rate is one pixel per clock.
//   Each pixel leaves as exactly one result word, marked by done_o for one
//   cycle, in the order the pixels arrived. The receiver cannot stall, so no
//   back pressure exists anywhere in the pipeline.
//   The result reaches the ports after the pixel passes four register stages:
//   the average and chroma, the norm and dot product, the cosine products,
//   and the gray decision with output.
//   The paper colour is written through the configuration channel (index 0
//   red, 1 green, 2 blue; index 3 is ignored), which is always ready. Writes
//   belong in idle periods; the paper chroma and its norm are derived through
//   registers, and a pixel taken after the write already sees the new colour.
//   Reset sets the paper to white, which has no tint, so all pixels pass
//   unchanged until a tinted paper colour is written. Reset empties the
//   pipeline: no result word follows a pixel that was in flight at reset.
// ----------------------------------------------------------------------------
module paper_cast_neutralizer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pcn_pkg::chan_t pixel_red_i,
  input  pcn_pkg::chan_t pixel_green_i,
  input  pcn_pkg::chan_t pixel_blue_i,
  output logic           done_o,
  output pcn_pkg::chan_t out_red_o,
  output pcn_pkg::chan_t out_green_o,
  output pcn_pkg::chan_t out_blue_o,
  output logic           was_neutralized_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  pcn_pkg::chan_t cfg_data_i
);
  import pcn_pkg::*;

  chroma_vec_t paper_chroma;
  norm_t       paper_norm2;
  front_t      front;
  metric_t     metric;
  logic        accept;

  // The pipeline never holds back, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  pcn_paper_regs u_paper (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .paper_chroma_o (paper_chroma),
    .paper_norm2_o  (paper_norm2)
  );

  // Stage one: average and chroma of the incoming pixel.
  pcn_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .red_i    (pixel_red_i),
    .green_i  (pixel_green_i),
    .blue_i   (pixel_blue_i),
    .front_o  (front)
  );

  // Stage two: squared norm and dot product against the paper chroma.
  pcn_metric u_metric (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .front_i        (front),
    .paper_chroma_i (paper_chroma),
    .metric_o       (metric)
  );

  // Stages three and four: cosine test and output register.
  pcn_decide u_decide (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .metric_i          (metric),
    .paper_norm2_i     (paper_norm2),
    .done_o            (done_o),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o),
    .was_neutralized_o (was_neutralized_o)
  );

  // Each accepted pixel raises done_o once it has passed the pipeline registers.
  a_every_pixel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted pixel produced no result");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result without an accepted pixel");

endmodule
